/* sv/assert_macros.svh */
// Assertion macros used by line_clip_rect.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lcr_pkg.sv */
// Package for the line clipper: defaults, register indexes, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 24;

  // Rectangle edges and clipped outputs are 15-bit unsigned.
  localparam int EDGE_W  = 15;
  localparam int CFG_IDX_W = 2;
  localparam logic [EDGE_W-1:0] OUT_MAX = {EDGE_W{1'b1}};

  localparam logic [EDGE_W-1:0] LEFT_RST   = EDGE_W'(0);
  localparam logic [EDGE_W-1:0] RIGHT_RST  = EDGE_W'(1024);
  localparam logic [EDGE_W-1:0] TOP_RST    = EDGE_W'(0);
  localparam logic [EDGE_W-1:0] BOTTOM_RST = EDGE_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_TOP    = 2'd2,
    REG_BOTTOM = 2'd3
  } cfg_reg_e;

  // Edge flags that ride along with each ratio.
  typedef struct packed {
    logic pzero;  // segment parallel to the edge
    logic qneg;   // start point outside the edge
    logic pneg;   // entering edge
  } ratio_flags_t;

endpackage

`default_nettype wire

/* sv/lcr_div.sv */
// Pipelined restoring divider: q/p as signed fixed point, saturated to [-2,2).
// Depends on lcr_pkg. One quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lcr_div #(
  parameter int MAG_W     = 17,
  parameter int FRAC_BITS = 24
) (
  input  wire                            clk_i,
  input  wire                            ce_i,
  input  wire logic signed [MAG_W:0]     q_i,
  input  wire logic signed [MAG_W:0]     p_i,
  output logic signed [FRAC_BITS+1:0]    r_o,
  output lcr_pkg::ratio_flags_t          flags_o
);
  import lcr_pkg::*;

  localparam int QW = FRAC_BITS + 1;

  // stage 0: magnitudes and signs
  logic [MAG_W-1:0] mq0_q, mp0_q;
  logic             neg0_q;
  ratio_flags_t     fl0_q;

  logic signed [MAG_W:0] nq, np;
  assign nq = -q_i;
  assign np = -p_i;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      mq0_q      <= q_i[MAG_W] ? nq[MAG_W-1:0] : q_i[MAG_W-1:0];
      mp0_q      <= p_i[MAG_W] ? np[MAG_W-1:0] : p_i[MAG_W-1:0];
      neg0_q     <= q_i[MAG_W] ^ p_i[MAG_W];
      fl0_q.pzero <= (p_i == '0);
      fl0_q.qneg  <= q_i[MAG_W];
      fl0_q.pneg  <= p_i[MAG_W];
    end
  end

  // stage k: k=0 integer bit, k>=1 fraction bits
  logic [MAG_W-1:0] rem_q [0:FRAC_BITS];
  logic [MAG_W-1:0] mp_q  [0:FRAC_BITS];
  logic [QW-1:0]    quo_q [0:FRAC_BITS];
  logic             sat_q [0:FRAC_BITS];
  logic             neg_q [0:FRAC_BITS];
  ratio_flags_t     fl_q  [0:FRAC_BITS];

  logic             ge0, sat0;
  logic [MAG_W-1:0] sub0;
  assign ge0  = (mq0_q >= mp0_q);
  assign sat0 = ({1'b0, mq0_q} >= {mp0_q, 1'b0});
  assign sub0 = mq0_q - mp0_q;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q[0] <= ge0 ? sub0 : mq0_q;
      mp_q[0]  <= mp0_q;
      quo_q[0] <= {{(QW-1){1'b0}}, ge0};
      sat_q[0] <= sat0;
      neg_q[0] <= neg0_q;
      fl_q[0]  <= fl0_q;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_iter
    logic [MAG_W:0] sh, df;
    logic           ge;
    assign sh = {rem_q[k-1], 1'b0};
    assign ge = (sh >= {1'b0, mp_q[k-1]});
    assign df = sh - {1'b0, mp_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[k] <= ge ? df[MAG_W-1:0] : sh[MAG_W-1:0];
        mp_q[k]  <= mp_q[k-1];
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
        sat_q[k] <= sat_q[k-1];
        neg_q[k] <= neg_q[k-1];
        fl_q[k]  <= fl_q[k-1];
      end
    end
  end

  // final stage: sign and saturation
  logic signed [QW:0] pos, neg;
  assign pos = $signed({1'b0, quo_q[FRAC_BITS]});
  assign neg = -pos;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      if (sat_q[FRAC_BITS]) begin
        r_o <= neg_q[FRAC_BITS] ? $signed({1'b1, {QW{1'b0}}})
                                : $signed({1'b0, {QW{1'b1}}});
      end else begin
        r_o <= neg_q[FRAC_BITS] ? neg : pos;
      end
      flags_o <= fl_q[FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

/* sv/line_clip_rect.sv */
// Liang-Barsky segment clipper against a configurable rectangle, top level.
// Depends on lcr_pkg, lcr_div and assert_macros.svh.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid/s_axis_tready     start_x, start_y, end_x, end_y
//  m_axis    out  m_axis_tvalid/m_axis_tready     accepted (tuser), clipped ends
//  cfg       in   cfg_we_i                        cfg_idx_i, cfg_data_i
//
// One word in per cycle while the pipeline is not held, one result per word;
// the four parallel bit-per-stage dividers (FRAC_BITS+3 stages) lie inside it.
// All stages move together; they hold only while the output register is
// full and not taken, so s_axis_tready = !m_axis_tvalid | m_axis_tready.
// Reset clears the valid bits and loads the default rectangle.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module line_clip_rect #(
  parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lcr_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((4*COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4*lcr_pkg::EDGE_W + 7) / 8) * 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x, start_y, end_x, end_y (COORD_BITS each), zero pad
  input  wire  [IN_W-1:0]                 s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // clip_start_x, clip_start_y, clip_end_x, clip_end_y (15 each), zero pad
  output logic [OUT_W-1:0]                m_axis_tdata,
  // accepted
  output logic                            m_axis_tuser,
  input  wire                             cfg_we_i,
  input  wire  [lcr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [lcr_pkg::EDGE_W-1:0]      cfg_data_i
);
  import lcr_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int MAG_W = ((C > 16) ? C : 16) + 1;  // holds |q| and |p|
  localparam int RW    = FRAC_BITS + 2;            // signed ratio
  localparam int TW    = FRAC_BITS + 1;            // t in [0,1]
  localparam int PW    = C + 1 + RW;               // delta * t
  localparam int XW    = MAG_W + 3;                // endpoint before clamp
  localparam int DLAT  = FRAC_BITS + 3;
  localparam int NST   = DLAT + 6;
  localparam int SB_W  = 2*C + 2*(C+1);

  // ---------------- configuration ----------------
  logic [EDGE_W-1:0] left_q, right_q, top_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= LEFT_RST;
      right_q  <= RIGHT_RST;
      top_q    <= TOP_RST;
      bottom_q <= BOTTOM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic           ce;
  logic [NST-1:0] vld_q;

  assign ce            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: deltas and edge distances ----------------
  logic signed [C-1:0]   in_sx, in_sy, in_ex, in_ey;
  logic signed [C-1:0]   sx1_q, sy1_q;
  logic signed [C:0]     dx1_q, dy1_q;
  logic signed [MAG_W:0] q1_q [0:3];

  assign in_sx = s_axis_tdata[C-1:0];
  assign in_sy = s_axis_tdata[2*C-1:C];
  assign in_ex = s_axis_tdata[3*C-1:2*C];
  assign in_ey = s_axis_tdata[4*C-1:3*C];

  logic signed [MAG_W:0] sx_w, sy_w;
  assign sx_w = (MAG_W+1)'(in_sx);
  assign sy_w = (MAG_W+1)'(in_sy);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sx1_q   <= in_sx;
      sy1_q   <= in_sy;
      dx1_q   <= (C+1)'(in_ex) - (C+1)'(in_sx);
      dy1_q   <= (C+1)'(in_ey) - (C+1)'(in_sy);
      q1_q[0] <= sx_w - $signed({{(MAG_W+1-EDGE_W){1'b0}}, left_q});
      q1_q[1] <= $signed({{(MAG_W+1-EDGE_W){1'b0}}, right_q}) - sx_w;
      q1_q[2] <= sy_w - $signed({{(MAG_W+1-EDGE_W){1'b0}}, top_q});
      q1_q[3] <= $signed({{(MAG_W+1-EDGE_W){1'b0}}, bottom_q}) - sy_w;
    end
  end

  // ---------------- dividers: one per edge ----------------
  logic signed [MAG_W:0] dxw, dyw;
  logic signed [MAG_W:0] p1 [0:3];
  assign dxw   = (MAG_W+1)'(dx1_q);
  assign dyw   = (MAG_W+1)'(dy1_q);
  assign p1[0] = -dxw;
  assign p1[1] = dxw;
  assign p1[2] = -dyw;
  assign p1[3] = dyw;

  logic signed [RW-1:0] rd [0:3];
  ratio_flags_t         fd [0:3];

  for (genvar e = 0; e < 4; e++) begin : g_div
    lcr_div #(
      .MAG_W     (MAG_W),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i   (clk_i),
      .ce_i    (ce),
      .q_i     (q1_q[e]),
      .p_i     (p1[e]),
      .r_o     (rd[e]),
      .flags_o (fd[e])
    );
  end

  // start point and deltas ride alongside the dividers
  logic [SB_W-1:0] sb_q [0:DLAT-1];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sb_q[0] <= {dy1_q, dx1_q, sy1_q, sx1_q};
      for (int i = 1; i < DLAT; i++) sb_q[i] <= sb_q[i-1];
    end
  end

  // ---------------- edge window update ----------------
  typedef struct packed {
    logic [TW-1:0] t0;
    logic [TW-1:0] t1;
    logic          rej;
  } win_t;

  function automatic win_t edge_step(win_t w, logic signed [RW-1:0] r, ratio_flags_t f);
    win_t o;
    logic signed [RW-1:0] st0, st1;
    o   = w;
    st0 = $signed({1'b0, w.t0});
    st1 = $signed({1'b0, w.t1});
    if (f.pzero) begin
      o.rej = w.rej | f.qneg;
    end else if (f.pneg) begin
      if (r > st1)      o.rej = 1'b1;
      else if (r > st0) o.t0  = r[TW-1:0];
    end else begin
      if (r < st0)      o.rej = 1'b1;
      else if (r < st1) o.t1  = r[TW-1:0];
    end
    return o;
  endfunction

  win_t                 w_init, w_e1a, w_e1, w_e2a, w_e2;
  win_t                 e1_q, e2_q;
  logic signed [RW-1:0] r2_q, r3_q;
  ratio_flags_t         f2_q, f3_q;
  logic [SB_W-1:0]      sbe1_q, sbe2_q;

  assign w_init = '{t0: '0, t1: {1'b1, {FRAC_BITS{1'b0}}}, rej: 1'b0};
  assign w_e1a  = edge_step(w_init, rd[0], fd[0]);
  assign w_e1   = edge_step(w_e1a, rd[1], fd[1]);
  assign w_e2a  = edge_step(e1_q, r2_q, f2_q);
  assign w_e2   = edge_step(w_e2a, r3_q, f3_q);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      e1_q   <= w_e1;
      r2_q   <= rd[2];
      r3_q   <= rd[3];
      f2_q   <= fd[2];
      f3_q   <= fd[3];
      sbe1_q <= sb_q[DLAT-1];
      e2_q   <= w_e2;
      sbe2_q <= sbe1_q;
    end
  end

  // ---------------- endpoint products ----------------
  logic signed [C-1:0] sx2, sy2;
  logic signed [C:0]   dx2, dy2;
  assign {dy2, dx2, sy2, sx2} = sbe2_q;

  logic signed [PW-1:0] pr_q [0:3];
  logic signed [C-1:0]  sxm_q, sym_q;
  logic                 accm_q;
  logic signed [RW-1:0] t0s, t1s;
  assign t0s = $signed({1'b0, e2_q.t0});
  assign t1s = $signed({1'b0, e2_q.t1});

  always_ff @(posedge clk_i) begin
    if (ce) begin
      pr_q[0] <= PW'(dx2) * PW'(t0s);
      pr_q[1] <= PW'(dy2) * PW'(t0s);
      pr_q[2] <= PW'(dx2) * PW'(t1s);
      pr_q[3] <= PW'(dy2) * PW'(t1s);
      sxm_q   <= sx2;
      sym_q   <= sy2;
      accm_q  <= !e2_q.rej;
    end
  end

  // start + floor, rounded toward zero when the sum is negative
  logic signed [XW-1:0] xa_q [0:3];
  logic                 acca_q;

  for (genvar j = 0; j < 4; j++) begin : g_add
    logic signed [XW-1:0] st, fl, x;
    logic                 fr;
    assign st = (j % 2 == 0) ? XW'(sxm_q) : XW'(sym_q);
    assign fl = XW'(pr_q[j] >>> FRAC_BITS);
    assign fr = |pr_q[j][FRAC_BITS-1:0];
    assign x  = st + fl;
    always_ff @(posedge clk_i) begin
      if (ce) xa_q[j] <= (x[XW-1] && fr) ? x + XW'(1) : x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) acca_q <= accm_q;
  end

  // ---------------- clamp and output register ----------------
  logic [EDGE_W-1:0] cl [0:3];

  for (genvar j = 0; j < 4; j++) begin : g_clamp
    always_comb begin
      priority if (!acca_q || xa_q[j][XW-1])  cl[j] = '0;
      else if (xa_q[j] > XW'(OUT_MAX))        cl[j] = OUT_MAX;
      else                                    cl[j] = xa_q[j][EDGE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      m_axis_tdata <= {{(OUT_W-4*EDGE_W){1'b0}}, cl[3], cl[2], cl[1], cl[0]};
      m_axis_tuser <= acca_q;
    end
  end

  // ---------------- assertions ----------------
  `LCR_ASSERT_IMP(a_rej_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0,
                  "rejected segment with nonzero endpoints")
  `LCR_ASSERT_NXT(a_hold, !ce, $stable(vld_q), "pipeline moved during a stall")
  `LCR_ASSERT_NXT(a_take, s_axis_tvalid && s_axis_tready, vld_q[0],
                  "accepted word lost at entry")
  `LCR_ASSERT_IMP(a_win, vld_q[DLAT+2] && !e2_q.rej, e2_q.t0 <= e2_q.t1,
                  "accepted segment with empty window")

endmodule

`default_nettype wire
